@@ design/mqtt_qos_pkg.sv @@
// ---------------------------------------------------------------------------
// MQTT QoS publish sender package
// Shared codes for the publish retry state machine and its port checker.
// ---------------------------------------------------------------------------
package mqtt_qos_pkg;

	localparam int unsigned TimeoutW = 16;
	localparam int unsigned RetryW   = 8;
	localparam int unsigned IdW      = 16;

	localparam logic [TimeoutW-1:0] TimeoutReset = 16'd1000;
	localparam logic [RetryW-1:0]   RetryReset   = 8'd3;

	// Register indexes on the configuration port.
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_RETRIES = 1'b1;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_ACK   = 2'd1,
		OP_TICK  = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ACK_PUBACK  = 2'd0,
		ACK_PUBREC  = 2'd1,
		ACK_PUBCOMP = 2'd2,
		ACK_BAD     = 2'd3
	} ack_kind_t;

	localparam logic [1:0] QOS_TWO = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_WACK  = 3'd1,
		PH_WREC  = 3'd2,
		PH_WCOMP = 3'd3,
		PH_DONE  = 3'd4,
		PH_FAIL  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ACT_NONE = 3'd0,
		ACT_PUB  = 3'd1,
		ACT_DUP  = 3'd2,
		ACT_REL  = 3'd3,
		ACT_DONE = 3'd4,
		ACT_FAIL = 3'd5,
		ACT_VIOL = 3'd6
	} action_t;

endpackage

@@ design/mqtt_qos_publish_retry_fsm.sv @@
// ---------------------------------------------------------------------------
// MQTT QoS publish retry state machine
// Sender side of one QoS 1 or QoS 2 publication with timed retransmission.
// ---------------------------------------------------------------------------
// Each accepted event (start, acknowledgement or timer tick) produces exactly
// one result transfer. An event is captured in an input register and is
// resolved against the publication state when the result register loads, so
// one event is taken every cycle as long as the result side keeps up. The
// result register is the only buffer on the output side: the input register
// holds while it is full and not being taken. Timeout and retry limit are to
// be written over the APB port only while no event is outstanding; the block
// itself does not enforce this.
module mqtt_qos_publish_retry_fsm (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// event channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [1:0]  qos_level,
	input  logic [15:0] packet_id,
	input  logic [1:0]  ack_type,
	input  logic [15:0] ack_id,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic [15:0] out_packet_id,
	output logic [2:0]  phase
);

	// Configuration registers.
	logic [mqtt_qos_pkg::TimeoutW-1:0] timeout_q;
	logic [mqtt_qos_pkg::RetryW-1:0]   max_retries_q;
	logic                              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q     <= mqtt_qos_pkg::TimeoutReset;
			max_retries_q <= mqtt_qos_pkg::RetryReset;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				mqtt_qos_pkg::REG_TIMEOUT: timeout_q     <= pwdata[15:0];
				mqtt_qos_pkg::REG_RETRIES: max_retries_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			mqtt_qos_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_q};
			mqtt_qos_pkg::REG_RETRIES: prdata = {24'd0, max_retries_q};
			default:                   prdata = 32'd0;
		endcase
	end

	// Input register.
	logic                          valid_s1;
	mqtt_qos_pkg::opcode_t         opcode_s1;
	logic [1:0]                    qos_s1;
	logic [mqtt_qos_pkg::IdW-1:0]  pid_s1;
	mqtt_qos_pkg::ack_kind_t       kind_s1;
	logic [mqtt_qos_pkg::IdW-1:0]  aid_s1;
	logic                          fire;

	logic                          out_valid_q;

	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= mqtt_qos_pkg::opcode_t'(opcode);
			qos_s1    <= qos_level;
			pid_s1    <= packet_id;
			kind_s1   <= mqtt_qos_pkg::ack_kind_t'(ack_type);
			aid_s1    <= ack_id;
		end
	end

	// Publication state.
	mqtt_qos_pkg::phase_t              phase_q, phase_d;
	logic [mqtt_qos_pkg::RetryW-1:0]   retry_q, retry_d;
	logic [mqtt_qos_pkg::TimeoutW-1:0] timer_q, timer_d;
	logic [mqtt_qos_pkg::IdW-1:0]      id_q, id_d;
	logic                              qos2_q, qos2_d;
	mqtt_qos_pkg::action_t             act_d;

	// Event decode.
	logic                              in_flight;
	logic                              id_match;
	logic                              start_take;
	logic                              ack_take;
	logic                              tick_take;
	logic                              ack_done;
	logic                              ack_rec;
	logic                              ack_viol;
	logic                              expire;
	logic                              retry_ok;
	logic                              start_qos2;
	logic [mqtt_qos_pkg::TimeoutW-1:0] arm_value;

	assign in_flight = (phase_q == mqtt_qos_pkg::PH_WACK) ||
		(phase_q == mqtt_qos_pkg::PH_WREC) || (phase_q == mqtt_qos_pkg::PH_WCOMP);
	assign id_match   = (aid_s1 == id_q);
	assign start_take = (opcode_s1 == mqtt_qos_pkg::OP_START) && !in_flight;
	assign ack_take   = (opcode_s1 == mqtt_qos_pkg::OP_ACK) && in_flight;
	assign tick_take  = (opcode_s1 == mqtt_qos_pkg::OP_TICK) && in_flight;
	assign start_qos2 = (qos_s1 == mqtt_qos_pkg::QOS_TWO);

	assign ack_done = ack_take && id_match &&
		(((phase_q == mqtt_qos_pkg::PH_WACK) && (kind_s1 == mqtt_qos_pkg::ACK_PUBACK)) ||
		 ((phase_q == mqtt_qos_pkg::PH_WCOMP) && (kind_s1 == mqtt_qos_pkg::ACK_PUBCOMP)));
	// A repeated PUBREC while waiting for PUBCOMP is answered with another PUBREL.
	assign ack_rec = ack_take && id_match && (kind_s1 == mqtt_qos_pkg::ACK_PUBREC) &&
		((phase_q == mqtt_qos_pkg::PH_WREC) || (phase_q == mqtt_qos_pkg::PH_WCOMP));
	assign ack_viol = ack_take && !ack_done && !ack_rec;

	assign expire    = tick_take && (timer_q <= 16'd1);
	assign retry_ok  = (retry_q < max_retries_q);
	assign arm_value = (timeout_q == '0) ? 16'd1 : timeout_q;

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			mqtt_qos_pkg::PH_IDLE,
			mqtt_qos_pkg::PH_DONE,
			mqtt_qos_pkg::PH_FAIL: begin
				if (start_take) begin
					phase_d = start_qos2 ? mqtt_qos_pkg::PH_WREC : mqtt_qos_pkg::PH_WACK;
				end
			end
			mqtt_qos_pkg::PH_WACK,
			mqtt_qos_pkg::PH_WREC,
			mqtt_qos_pkg::PH_WCOMP: begin
				if (ack_done) begin
					phase_d = mqtt_qos_pkg::PH_DONE;
				end else if (ack_rec) begin
					phase_d = mqtt_qos_pkg::PH_WCOMP;
				end else if (ack_viol || (expire && !retry_ok)) begin
					phase_d = mqtt_qos_pkg::PH_FAIL;
				end
			end
			default: phase_d = phase_q;
		endcase
	end

	// Action, timer, retry budget and stored publication.
	always_comb begin
		act_d   = mqtt_qos_pkg::ACT_NONE;
		timer_d = timer_q;
		retry_d = retry_q;
		id_d    = id_q;
		qos2_d  = qos2_q;
		if (start_take) begin
			act_d   = mqtt_qos_pkg::ACT_PUB;
			timer_d = arm_value;
			retry_d = '0;
			id_d    = pid_s1;
			qos2_d  = start_qos2;
		end else if (ack_done) begin
			act_d = mqtt_qos_pkg::ACT_DONE;
		end else if (ack_rec) begin
			act_d   = mqtt_qos_pkg::ACT_REL;
			timer_d = arm_value;
		end else if (ack_viol) begin
			act_d = mqtt_qos_pkg::ACT_VIOL;
		end else if (tick_take) begin
			if (!expire) begin
				timer_d = timer_q - 16'd1;
			end else if (retry_ok) begin
				timer_d = arm_value;
				retry_d = retry_q + 8'd1;
				act_d   = (phase_q == mqtt_qos_pkg::PH_WCOMP) ?
					mqtt_qos_pkg::ACT_REL : mqtt_qos_pkg::ACT_DUP;
			end else begin
				timer_d = '0;
				act_d   = mqtt_qos_pkg::ACT_FAIL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mqtt_qos_pkg::PH_IDLE;
			retry_q <= '0;
			timer_q <= '0;
			id_q    <= '0;
			qos2_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			retry_q <= retry_d;
			timer_q <= timer_d;
			id_q    <= id_d;
			qos2_q  <= qos2_d;
		end
	end

	// Result register.
	logic [2:0]                   action_q;
	logic [mqtt_qos_pkg::IdW-1:0] out_id_q;
	logic [2:0]                   phase_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			action_q    <= act_d;
			out_id_q    <= (act_d == mqtt_qos_pkg::ACT_NONE) ? '0 : id_d;
			phase_out_q <= phase_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = action_q;
	assign out_packet_id = out_id_q;
	assign phase         = phase_out_q;

endmodule

@@ design/mqtt_qos_chk.sv @@
// ---------------------------------------------------------------------------
// MQTT QoS publish sender port checker
// Checks result transfers against the phase they report, seen at the ports.
// ---------------------------------------------------------------------------
module mqtt_qos_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  action,
	input logic [15:0] out_packet_id,
	input logic [2:0]  phase
);

	// A stalled result transfer keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) &&
		$stable(out_packet_id) && $stable(phase))
		else $error("result payload changed while stalled");

	a_none_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == mqtt_qos_pkg::ACT_NONE) |-> (out_packet_id == 16'd0))
		else $error("no-action result carries a packet id");

	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == mqtt_qos_pkg::ACT_DONE) |-> (phase == mqtt_qos_pkg::PH_DONE))
		else $error("completion reported outside the completed phase");

	a_fail_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((action == mqtt_qos_pkg::ACT_FAIL) ||
		(action == mqtt_qos_pkg::ACT_VIOL)) |-> (phase == mqtt_qos_pkg::PH_FAIL))
		else $error("failure or violation reported outside the failed phase");

	// Sending a packet always leaves the publication in flight.
	a_send_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((action == mqtt_qos_pkg::ACT_PUB) || (action == mqtt_qos_pkg::ACT_DUP) ||
		(action == mqtt_qos_pkg::ACT_REL)) |->
		((phase == mqtt_qos_pkg::PH_WACK) || (phase == mqtt_qos_pkg::PH_WREC) ||
		(phase == mqtt_qos_pkg::PH_WCOMP)))
		else $error("packet sent while not in flight");

endmodule

bind mqtt_qos_publish_retry_fsm mqtt_qos_chk u_mqtt_qos_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.action        (action),
	.out_packet_id (out_packet_id),
	.phase         (phase)
);

@@ dv/tb_mqtt_qos_publish_retry_fsm.sv @@
// ---------------------------------------------------------------------------
// Testbench for the MQTT QoS publish retry state machine
// Sends start, acknowledgement and timer tick events under a series of
// timeout and retry limits, predicts every result transfer and checks it
// field by field, with random gaps on the event side and random stalls and
// one long hold-off on the result side.
// ---------------------------------------------------------------------------
module tb_mqtt_qos_publish_retry_fsm;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 400000;

	typedef struct {
		mqtt_qos_pkg::opcode_t   op;
		logic [1:0]              qos;
		logic [15:0]             pid;
		mqtt_qos_pkg::ack_kind_t kind;
		logic [15:0]             aid;
	} event_t;

	typedef struct {
		mqtt_qos_pkg::action_t act;
		logic [15:0]           id;
		mqtt_qos_pkg::phase_t  ph;
	} pub_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = '0;
	logic [1:0]  qos_level = '0;
	logic [15:0] packet_id = '0;
	logic [1:0]  ack_type = '0;
	logic [15:0] ack_id = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  action;
	logic [15:0] out_packet_id;
	logic [2:0]  phase;

	mqtt_qos_publish_retry_fsm i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.qos_level     (qos_level),
		.packet_id     (packet_id),
		.ack_type      (ack_type),
		.ack_id        (ack_id),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.action        (action),
		.out_packet_id (out_packet_id),
		.phase         (phase)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Shadow copy of the publication state and the limits.
	logic [15:0]          cfg_timeout = mqtt_qos_pkg::TimeoutReset;
	logic [7:0]           cfg_max_retries = mqtt_qos_pkg::RetryReset;
	mqtt_qos_pkg::phase_t cur_phase = mqtt_qos_pkg::PH_IDLE;
	logic [7:0]           retries_used = '0;
	logic [15:0]          ticks_left = '0;
	logic [15:0]          pub_id = '0;
	logic                 pub_qos2 = 1'b0;

	event_t      events_to_send[$];
	pub_result_t awaited_results[$];
	event_t      cur_event;
	int          queued_total = 0;
	int          events_taken = 0;
	int          results_seen = 0;
	int          mismatch_cnt = 0;
	int          settings_used = 1;
	int          act_hits[8];
	int          burst_left = 1;
	int          gap_left = 0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;
	int          rx_cyc = 0;
	int          cycle_cnt = 0;

	function automatic logic [15:0] armed_ticks();
		return (cfg_timeout == '0) ? 16'd1 : cfg_timeout;
	endfunction

	function automatic pub_result_t publish_step(input event_t e);
		pub_result_t r;
		logic        busy;
		logic        match;
		r.act = mqtt_qos_pkg::ACT_NONE;
		busy = (cur_phase == mqtt_qos_pkg::PH_WACK) || (cur_phase == mqtt_qos_pkg::PH_WREC) ||
			(cur_phase == mqtt_qos_pkg::PH_WCOMP);
		match = (e.aid == pub_id);
		case (e.op)
			mqtt_qos_pkg::OP_START: begin
				if (!busy) begin
					pub_id = e.pid;
					pub_qos2 = (e.qos == mqtt_qos_pkg::QOS_TWO);
					retries_used = '0;
					cur_phase = pub_qos2 ? mqtt_qos_pkg::PH_WREC : mqtt_qos_pkg::PH_WACK;
					ticks_left = armed_ticks();
					r.act = mqtt_qos_pkg::ACT_PUB;
				end
			end
			mqtt_qos_pkg::OP_ACK: begin
				if (busy) begin
					if (cur_phase == mqtt_qos_pkg::PH_WACK &&
						e.kind == mqtt_qos_pkg::ACK_PUBACK && match) begin
						cur_phase = mqtt_qos_pkg::PH_DONE;
						r.act = mqtt_qos_pkg::ACT_DONE;
					end else if (cur_phase != mqtt_qos_pkg::PH_WACK &&
						e.kind == mqtt_qos_pkg::ACK_PUBREC && match) begin
						cur_phase = mqtt_qos_pkg::PH_WCOMP;
						ticks_left = armed_ticks();
						r.act = mqtt_qos_pkg::ACT_REL;
					end else if (cur_phase == mqtt_qos_pkg::PH_WCOMP &&
						e.kind == mqtt_qos_pkg::ACK_PUBCOMP && match) begin
						cur_phase = mqtt_qos_pkg::PH_DONE;
						r.act = mqtt_qos_pkg::ACT_DONE;
					end else begin
						cur_phase = mqtt_qos_pkg::PH_FAIL;
						r.act = mqtt_qos_pkg::ACT_VIOL;
					end
				end
			end
			mqtt_qos_pkg::OP_TICK: begin
				if (busy) begin
					if (ticks_left > 16'd1) begin
						ticks_left = ticks_left - 16'd1;
					end else begin
						ticks_left = '0;
						// Both QoS 2 phases draw on the same retry budget.
						if (retries_used < cfg_max_retries) begin
							retries_used = retries_used + 8'd1;
							ticks_left = armed_ticks();
							r.act = (cur_phase == mqtt_qos_pkg::PH_WCOMP) ?
								mqtt_qos_pkg::ACT_REL : mqtt_qos_pkg::ACT_DUP;
						end else begin
							cur_phase = mqtt_qos_pkg::PH_FAIL;
							r.act = mqtt_qos_pkg::ACT_FAIL;
						end
					end
				end
			end
			default: ;
		endcase
		r.id = (r.act == mqtt_qos_pkg::ACT_NONE) ? 16'd0 : pub_id;
		r.ph = cur_phase;
		return r;
	endfunction

	function automatic event_t junk_event(input mqtt_qos_pkg::opcode_t op);
		event_t e;
		e.op = op;
		e.qos = 2'($urandom);
		e.pid = 16'($urandom);
		e.kind = mqtt_qos_pkg::ack_kind_t'(2'($urandom));
		e.aid = 16'($urandom);
		return e;
	endfunction

	task automatic push_event(input event_t e);
		events_to_send.push_back(e);
		queued_total++;
	endtask

	task automatic add_start(input logic [1:0] qos, input logic [15:0] pid);
		event_t e;
		e = junk_event(mqtt_qos_pkg::OP_START);
		e.qos = qos;
		e.pid = pid;
		push_event(e);
	endtask

	task automatic add_ack(input mqtt_qos_pkg::ack_kind_t kind, input logic [15:0] aid);
		event_t e;
		e = junk_event(mqtt_qos_pkg::OP_ACK);
		e.kind = kind;
		e.aid = aid;
		push_event(e);
	endtask

	task automatic add_ticks(input int n);
		repeat (n) push_event(junk_event(mqtt_qos_pkg::OP_TICK));
	endtask

	// Mostly the expected answer, now and then a wrong kind or a corrupted id.
	task automatic add_reply(input mqtt_qos_pkg::ack_kind_t kind, input logic [15:0] aid);
		if ($urandom_range(0, 9) == 0) begin
			if ($urandom_range(0, 1) != 0)
				kind = mqtt_qos_pkg::ack_kind_t'(2'($urandom));
			else
				aid = aid ^ (16'd1 << $urandom_range(0, 15));
		end
		add_ack(kind, aid);
	endtask

	task automatic queue_publication();
		logic [15:0] id;
		logic [1:0]  qos;
		id = 16'($urandom);
		if ($urandom_range(0, 4) == 0)
			qos = ($urandom_range(0, 1) != 0) ? 2'd3 : 2'd0;
		else
			qos = ($urandom_range(0, 1) != 0) ? mqtt_qos_pkg::QOS_TWO : 2'd1;
		add_start(qos, id);
		add_ticks($urandom_range(0, 3));
		if (qos != mqtt_qos_pkg::QOS_TWO) begin
			add_reply(mqtt_qos_pkg::ACK_PUBACK, id);
		end else begin
			add_reply(mqtt_qos_pkg::ACK_PUBREC, id);
			if ($urandom_range(0, 4) == 0)
				add_reply(mqtt_qos_pkg::ACK_PUBREC, id);
			add_ticks($urandom_range(0, 3));
			add_reply(mqtt_qos_pkg::ACK_PUBCOMP, id);
		end
	endtask

	task automatic queue_traffic(input int n);
		int stop_at;
		stop_at = queued_total + n;
		while (queued_total < stop_at) begin
			if ($urandom_range(0, 9) < 7)
				queue_publication();
			else
				repeat ($urandom_range(1, 4))
					push_event(junk_event(mqtt_qos_pkg::opcode_t'(2'($urandom))));
		end
	endtask

	// Lets everything drain before the limits are changed.
	task automatic settle();
		while (!(events_to_send.size() == 0 && !in_valid && awaited_results.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_limits(input logic [15:0] ticks, input logic [7:0] retries);
		write_reg(mqtt_qos_pkg::REG_TIMEOUT, {16'd0, ticks});
		write_reg(mqtt_qos_pkg::REG_RETRIES, {24'd0, retries});
		cfg_timeout = ticks;
		cfg_max_retries = retries;
		settings_used++;
	endtask

	task automatic flag_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Event driver: bursts of transfers separated by random gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				awaited_results.push_back(publish_step(cur_event));
				events_taken++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (events_to_send.size() > 0) begin
					cur_event = events_to_send.pop_front();
					opcode <= cur_event.op;
					qos_level <= cur_event.qos;
					packet_id <= cur_event.pid;
					ack_type <= cur_event.kind;
					ack_id <= cur_event.aid;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// One long hold-off on the result side once traffic is well under way.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= 400) begin
			hold_left <= 300;
			hold_done <= 1'b1;
		end
	end

	// Result monitor and checker; the stall pattern steps through an always-ready mode and three stalling modes.
	always @(posedge clk) begin
		pub_result_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				act_hits[action]++;
				if (awaited_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected result action=%0d id=%h phase=%0d",
						action, out_packet_id, phase));
				end else begin
					exp_r = awaited_results.pop_front();
					if (action !== exp_r.act || out_packet_id !== exp_r.id || phase !== exp_r.ph)
						flag_mismatch($sformatf(
							"expected action=%0d id=%h phase=%0d, got action=%0d id=%h phase=%0d",
							exp_r.act, exp_r.id, exp_r.ph, action, out_packet_id, phase));
				end
			end
			rx_cyc++;
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else begin
				case (rx_cyc[8:7])
					2'd0: out_ready <= 1'b1;
					2'd1: out_ready <= ($urandom_range(0, 1) != 0);
					2'd2: out_ready <= (rx_cyc[1:0] != 2'd0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CycleLimit) begin
			$display("Timed out with %0d results still awaited", awaited_results.size());
			$display("** mqtt_qos_publish_retry_fsm: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [15:0] long_id;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Limits as they come out of reset.
		queue_traffic(100);
		settle();

		// Directed cases with a zero timeout, which counts as one tick.
		set_limits(16'd0, 8'd1);
		add_ticks(1);
		add_ack(mqtt_qos_pkg::ACK_PUBACK, 16'h0000);
		push_event(junk_event(mqtt_qos_pkg::OP_NOP));
		add_start(2'd1, 16'h0000);
		add_start(mqtt_qos_pkg::QOS_TWO, 16'hFFFF);
		add_ticks(2);
		add_ack(mqtt_qos_pkg::ACK_PUBACK, 16'h0000);
		add_start(2'd1, 16'hFFFF);
		add_ack(mqtt_qos_pkg::ACK_PUBACK, 16'hFFFF);
		add_start(mqtt_qos_pkg::QOS_TWO, 16'hA5A5);
		add_ack(mqtt_qos_pkg::ACK_PUBACK, 16'hA5A5);
		add_start(2'd3, 16'h5A5A);
		add_ack(mqtt_qos_pkg::ACK_PUBACK, 16'h5A5B);
		add_start(2'd0, 16'h0001);
		add_ack(mqtt_qos_pkg::ACK_BAD, 16'h0001);
		add_start(mqtt_qos_pkg::QOS_TWO, 16'h1234);
		add_ticks(1);
		add_ack(mqtt_qos_pkg::ACK_PUBREC, 16'h1234);
		add_ack(mqtt_qos_pkg::ACK_PUBREC, 16'h1234);
		add_ticks(1);
		add_start(mqtt_qos_pkg::QOS_TWO, 16'h8001);
		add_ack(mqtt_qos_pkg::ACK_PUBREC, 16'h8001);
		add_ack(mqtt_qos_pkg::ACK_PUBCOMP, 16'h8001);
		add_start(mqtt_qos_pkg::QOS_TWO, 16'h0002);
		add_ack(mqtt_qos_pkg::ACK_PUBCOMP, 16'h0002);
		settle();

		set_limits(16'd1, 8'd0);
		queue_traffic(200);
		settle();

		set_limits(16'd3, 8'd2);
		queue_traffic(300);
		settle();

		// Full retry budget spent across both QoS 2 phases.
		set_limits(16'd1, 8'd255);
		long_id = 16'($urandom);
		add_start(mqtt_qos_pkg::QOS_TWO, long_id);
		add_ticks(100);
		add_ack(mqtt_qos_pkg::ACK_PUBREC, long_id);
		add_ticks(157);
		queue_traffic(100);
		settle();

		set_limits(16'hFFFF, 8'd4);
		queue_traffic(100);
		settle();

		set_limits(16'd2, 8'd1);
		queue_traffic(120);
		settle();

		$display("Sent %0d events and checked %0d results over %0d limit settings",
			events_taken, results_seen, settings_used);
		$display("Seen: %0d dup publish, %0d PUBREL, %0d completed, %0d failed, %0d violations",
			act_hits[mqtt_qos_pkg::ACT_DUP], act_hits[mqtt_qos_pkg::ACT_REL],
			act_hits[mqtt_qos_pkg::ACT_DONE], act_hits[mqtt_qos_pkg::ACT_FAIL],
			act_hits[mqtt_qos_pkg::ACT_VIOL]);
		if (mismatch_cnt == 0)
			$display("** mqtt_qos_publish_retry_fsm: PASSED **");
		else
			$display("** mqtt_qos_publish_retry_fsm: FAILED **");
		$finish;
	end

endmodule
